// ===== hw/rtl/ufp_pkg.sv =====
// Shared constants and types for the ultrasonic frame parser.
`timescale 1ns / 1ps

package ufp_pkg;

  // Frame framing bytes
  localparam logic [7:0] SYNC_BYTE = 8'hAA;
  localparam logic [7:0] TYPE_DIST = 8'h00;

  // Fixed frame offsets of the type byte and the two distances
  localparam int TYPE_POS      = 2;
  localparam int FIRST_LO_POS  = 4;
  localparam int FIRST_HI_POS  = 5;
  localparam int SECOND_LO_POS = 34;
  localparam int SECOND_HI_POS = 35;

  // Configuration space
  localparam int          CFG_ADDR_W    = 3;
  localparam int          CFG_DATA_W    = 32;
  localparam logic [0:0]  REG_NO_ECHO   = 1'b0;
  localparam logic [15:0] NO_ECHO_RESET = 16'd5000;

  // Sync hunt state
  typedef enum logic [2:0] {
    PH_HUNT  = 3'b001,
    PH_ONE   = 3'b010,
    PH_FRAME = 3'b100
  } phase_t;

  // Request from the parser to the result stage
  typedef struct packed {
    logic        emit;
    logic [15:0] first_raw;
    logic [15:0] second_raw;
  } frame_result_t;

endpackage

// ===== hw/rtl/ufp_if.sv =====
// Handshake channels for received bytes and parsed distances.
`timescale 1ns / 1ps

interface ufp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface ufp_dist_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_distance;
  logic [15:0] second_distance;
  logic [15:0] nearest_distance;

  modport source (output valid, output first_distance, output second_distance,
                  output nearest_distance, input ready);
  modport sink (input valid, input first_distance, input second_distance,
                input nearest_distance, output ready);
endinterface

// ===== hw/rtl/ufp_cfg_regs.sv =====
// APB configuration register holding the no-echo distance.
`timescale 1ns / 1ps

module ufp_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ufp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ufp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ufp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output logic [15:0]                    no_echo_distance
);
  import ufp_pkg::*;

  logic sel_no_echo;

  assign pready      = 1'b1;
  assign sel_no_echo = (paddr[CFG_ADDR_W-1:2] == REG_NO_ECHO);

  // Write on the access phase; other addresses drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      no_echo_distance <= NO_ECHO_RESET;
    end else if (psel && penable && pwrite && pready && sel_no_echo) begin
      no_echo_distance <= pwdata[15:0];
    end
  end

  // Read back the register, zero elsewhere
  always_comb begin
    prdata = '0;
    if (sel_no_echo) begin
      prdata = {{(CFG_DATA_W-16){1'b0}}, no_echo_distance};
    end
  end

endmodule

// ===== hw/rtl/ufp_frame_parse.sv =====
// Input byte register, sync hunt and distance capture.
`timescale 1ns / 1ps

module ufp_frame_parse #(
  parameter int FRAME_BYTES = 38
) (
  input  logic                   clk,
  input  logic                   rst,
  ufp_byte_if.sink               rx,
  input  logic                   res_can_load,
  output ufp_pkg::frame_result_t frame_res
);
  import ufp_pkg::*;

  localparam int                POS_W    = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0]  LAST_POS = POS_W'(FRAME_BYTES - 1);

  logic             byte_valid;
  logic [7:0]       byte_q;
  logic             advance;

  phase_t           phase, phase_next;
  logic [POS_W-1:0] pos, pos_next;
  logic             type_matches, type_matches_next;
  logic [7:0]       held_low_byte, held_low_byte_next;
  logic [15:0]      captured_first, captured_first_next;
  logic [15:0]      captured_second, captured_second_next;

  assign advance  = byte_valid && res_can_load;
  assign rx.ready = !byte_valid || advance;

  // Hold the accepted byte until the parser consumes it
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx.ready) begin
      byte_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      byte_q <= rx.rx_byte;
    end
  end

  // Parse one byte: sync hunt, then count off the frame
  always_comb begin
    phase_next           = phase;
    pos_next             = pos;
    type_matches_next    = type_matches;
    held_low_byte_next   = held_low_byte;
    captured_first_next  = captured_first;
    captured_second_next = captured_second;
    frame_res.emit       = 1'b0;
    frame_res.first_raw  = captured_first;
    // Second distance may complete on the last byte of a short frame
    frame_res.second_raw = (pos == POS_W'(SECOND_HI_POS)) ? {byte_q, held_low_byte}
                                                          : captured_second;
    if (advance) begin
      case (phase)
        PH_ONE: begin
          if (byte_q == SYNC_BYTE) begin
            phase_next = PH_FRAME;
            pos_next   = POS_W'(TYPE_POS);
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_FRAME: begin
          case (pos)
            POS_W'(TYPE_POS):      type_matches_next    = (byte_q == TYPE_DIST);
            POS_W'(FIRST_LO_POS):  held_low_byte_next   = byte_q;
            POS_W'(SECOND_LO_POS): held_low_byte_next   = byte_q;
            POS_W'(FIRST_HI_POS):  captured_first_next  = {byte_q, held_low_byte};
            POS_W'(SECOND_HI_POS): captured_second_next = {byte_q, held_low_byte};
            default: ;
          endcase
          if (pos >= LAST_POS) begin
            phase_next     = PH_HUNT;
            pos_next       = '0;
            frame_res.emit = type_matches;
          end else begin
            pos_next = pos + 1'b1;
          end
        end
        default: begin
          phase_next = (byte_q == SYNC_BYTE) ? PH_ONE : PH_HUNT;
        end
      endcase
    end
  end

  // Advance parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT;
      pos             <= '0;
      type_matches    <= 1'b0;
      held_low_byte   <= '0;
      captured_first  <= '0;
      captured_second <= '0;
    end else begin
      phase           <= phase_next;
      pos             <= pos_next;
      type_matches    <= type_matches_next;
      held_low_byte   <= held_low_byte_next;
      captured_first  <= captured_first_next;
      captured_second <= captured_second_next;
    end
  end

endmodule

// ===== hw/rtl/ufp_result_stage.sv =====
// Zero replacement, minimum and the output register.
`timescale 1ns / 1ps

module ufp_result_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  ufp_pkg::frame_result_t frame_res,
  input  logic [15:0]            no_echo_distance,
  output logic                   res_can_load,
  ufp_dist_if.source             res
);
  import ufp_pkg::*;

  logic [15:0] d0, d1;

  assign res_can_load = !res.valid || res.ready;

  // Substitute the no-echo value for a zero reading
  assign d0 = (frame_res.first_raw == '0) ? no_echo_distance : frame_res.first_raw;
  assign d1 = (frame_res.second_raw == '0) ? no_echo_distance : frame_res.second_raw;

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (res_can_load) begin
      res.valid <= frame_res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (res_can_load && frame_res.emit) begin
      res.first_distance   <= d0;
      res.second_distance  <= d1;
      res.nearest_distance <= (d0 < d1) ? d0 : d1;
    end
  end

endmodule

// ===== hw/rtl/ultrasonic_frame_parser.sv =====
// Top level of the ultrasonic frame parser.
`timescale 1ns / 1ps

// Takes one received byte per cycle on rx and hunts for the sync pair 0xAA 0xAA,
// then counts off a FRAME_BYTES-long frame (sync bytes included). For a frame of
// type 0x00 it emits one result on res at the frame's last byte: the little-endian
// distances from offsets 4-5 and 34-35, each zero replaced by the no_echo_distance
// register (APB address 0, reset 5000), and their minimum. Other frames give no
// result. A byte is held in the input register and parsed combinationally, and a
// finished result is loaded into the output register that drives res.
// The input stalls only while a finished result waits in the output register.
module ultrasonic_frame_parser #(
  parameter int FRAME_BYTES = 38
) (
  input  logic                           clk,
  input  logic                           rst,
  ufp_byte_if.sink                       rx,
  ufp_dist_if.source                     res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ufp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ufp_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ufp_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import ufp_pkg::*;

  logic          [15:0] no_echo_distance;
  logic                 res_can_load;
  frame_result_t        frame_res;

  ufp_cfg_regs u_cfg (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .no_echo_distance (no_echo_distance)
  );

  ufp_frame_parse #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_parse (
    .clk          (clk),
    .rst          (rst),
    .rx           (rx),
    .res_can_load (res_can_load),
    .frame_res    (frame_res)
  );

  ufp_result_stage u_result (
    .clk              (clk),
    .rst              (rst),
    .frame_res        (frame_res),
    .no_echo_distance (no_echo_distance),
    .res_can_load     (res_can_load),
    .res              (res)
  );

endmodule

// ===== verif/ufp_frame_checker.sv =====
// Checker for the ultrasonic frame parser: predicts distance results and compares them.
`timescale 1ns / 1ps

module ufp_frame_checker #(
  parameter int FRAME_BYTES = 38
) (
  input  logic                           clk,
  input  logic                           rst,
  ufp_byte_if                            rx,
  ufp_dist_if                            res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ufp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ufp_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic                           pready,
  output int                             mismatches,
  output int                             pending,
  output int                             predicted,
  output int                             delivered
);
  import ufp_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] NO_ECHO_ADDR = {REG_NO_ECHO, 2'b00};
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [15:0] first;
    logic [15:0] second;
    logic [15:0] nearest;
  } distance_set_t;

  // Own copy of the parser state and the no-echo register
  phase_t      phase;
  logic [5:0]  pos;
  logic        dist_frame;
  logic [7:0]  low_hold;
  logic [15:0] first_raw;
  logic [15:0] second_raw;
  logic [15:0] no_echo;

  distance_set_t expected_q[$];
  int            mismatch_n;
  int            predicted_n;
  int            delivered_n;

  function automatic logic [15:0] fill_no_echo(input logic [15:0] raw);
    return (raw == 16'd0) ? no_echo : raw;
  endfunction

  // Advance the parser by one byte; queue a distance set at the end of a distance frame
  task automatic advance_parser(input logic [7:0] b);
    distance_set_t d;
    if (phase == PH_ONE) begin
      if (b == SYNC_BYTE) begin
        phase = PH_FRAME;
        pos   = 6'd2;
      end else begin
        phase = PH_HUNT;
      end
    end else if (phase != PH_FRAME) begin
      phase = (b == SYNC_BYTE) ? PH_ONE : PH_HUNT;
    end else begin
      case (pos)
        TYPE_POS:                    dist_frame = (b == TYPE_DIST);
        FIRST_LO_POS, SECOND_LO_POS: low_hold = b;
        FIRST_HI_POS:                first_raw = {b, low_hold};
        SECOND_HI_POS:               second_raw = {b, low_hold};
        default: ;
      endcase
      if (pos >= 6'(FRAME_BYTES - 1)) begin
        phase = PH_HUNT;
        pos   = 6'd0;
        if (dist_frame) begin
          d.first   = fill_no_echo(first_raw);
          d.second  = fill_no_echo(second_raw);
          d.nearest = (d.first < d.second) ? d.first : d.second;
          expected_q.push_back(d);
          predicted_n++;
        end
      end else begin
        pos = pos + 6'd1;
      end
    end
  endtask

  // Compare one delivered result with the oldest prediction
  task automatic check_result();
    distance_set_t got;
    distance_set_t exp_set;
    got.first   = res.first_distance;
    got.second  = res.second_distance;
    got.nearest = res.nearest_distance;
    delivered_n++;
    if (expected_q.size() == 0) begin
      mismatch_n++;
      if (mismatch_n <= REPORT_LIMIT)
        $display("%0t: result %h/%h/%h with no frame pending", $time,
                 got.first, got.second, got.nearest);
    end else begin
      exp_set = expected_q.pop_front();
      if (got != exp_set) begin
        mismatch_n++;
        if (mismatch_n <= REPORT_LIMIT)
          $display("%0t: distance mismatch, expected %h/%h/%h got %h/%h/%h", $time,
                   exp_set.first, exp_set.second, exp_set.nearest,
                   got.first, got.second, got.nearest);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase      = PH_HUNT;
      pos        = 6'd0;
      dist_frame = 1'b0;
      low_hold   = 8'd0;
      first_raw  = 16'd0;
      second_raw = 16'd0;
      no_echo    = NO_ECHO_RESET;
      expected_q.delete();
    end else begin
      // Track register writes; other addresses are ignored
      if (psel && penable && pwrite && pready && paddr == NO_ECHO_ADDR)
        no_echo = pwdata[15:0];
      if (rx.valid && rx.ready)
        advance_parser(rx.rx_byte);
      if (res.valid && res.ready)
        check_result();
    end
    mismatches <= mismatch_n;
    pending    <= expected_q.size();
    predicted  <= predicted_n;
    delivered  <= delivered_n;
  end

endmodule

// ===== verif/ultrasonic_frame_parser_tb.sv =====
// Testbench top for the ultrasonic frame parser: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module ultrasonic_frame_parser_tb;
  import ufp_pkg::*;

  localparam int FRAME_BYTES     = 38;
  localparam int ITEM_TARGET     = 1750;
  localparam int PHASE_ITEMS     = 370;
  localparam int SETTLE_CYCLES   = 6;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_LIMIT      = 3000;

  localparam logic [CFG_ADDR_W-1:0] NO_ECHO_ADDR = {REG_NO_ECHO, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR   = NO_ECHO_ADDR + 3'd4;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  int  mismatches;
  int  pending;
  int  predicted;
  int  delivered;
  int  bytes_sent;
  int  idle_cycles;
  int  settings_used;
  bit  steady_sender;
  bit  hold_off_req;

  ufp_byte_if rx_ch ();
  ufp_dist_if res_ch ();

  ultrasonic_frame_parser #(
    .FRAME_BYTES(FRAME_BYTES)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx_ch),
    .res    (res_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  ufp_frame_checker #(
    .FRAME_BYTES(FRAME_BYTES)
  ) i_checker (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx_ch),
    .res       (res_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .mismatches(mismatches),
    .pending   (pending),
    .predicted (predicted),
    .delivered (delivered)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Payload byte with sync bytes planted often
  function automatic logic [7:0] pick_data_byte();
    if ($urandom_range(0, 99) < 15) return SYNC_BYTE;
    return 8'($urandom_range(0, 255));
  endfunction

  // Distances weighted toward zero and the extremes
  function automatic logic [15:0] pick_distance();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) return 16'd0;
    if (r < 30) return 16'hFFFF;
    if (r < 38) return 16'd1;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Offer one byte, hold until accepted, then idle for a while
  task automatic send_byte(input logic [7:0] b);
    int gap;
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do @(posedge clk); while (!rx_ch.ready);
    bytes_sent++;
    gap = steady_sender ? 0 : pick_gap();
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [7:0] kind, input logic [15:0] first,
                            input logic [15:0] second);
    logic [7:0] b;
    for (int i = 0; i < FRAME_BYTES; i++) begin
      if (i < 2) b = SYNC_BYTE;
      else if (i == TYPE_POS) b = kind;
      else if (i == FIRST_LO_POS) b = first[7:0];
      else if (i == FIRST_HI_POS) b = first[15:8];
      else if (i == SECOND_LO_POS) b = second[7:0];
      else if (i == SECOND_HI_POS) b = second[15:8];
      else b = pick_data_byte();
      send_byte(b);
    end
  endtask

  task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Drop valid, wait for every expected result, then let the pipeline empty
  task automatic settle();
    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random burst: a well-formed frame, a sync byte with a random second byte, or line noise
  task automatic send_random_burst();
    int r;
    logic [7:0] kind;
    logic [15:0] first;
    logic [15:0] second;
    r = $urandom_range(0, 99);
    steady_sender = ($urandom_range(0, 3) == 0);
    if (r < 75) begin
      kind   = ($urandom_range(0, 99) < 85) ? TYPE_DIST : pick_data_byte();
      first  = pick_distance();
      second = ($urandom_range(0, 9) == 0) ? first : pick_distance();
      send_frame(kind, first, second);
    end else if (r < 88) begin
      send_byte(SYNC_BYTE);
      send_byte(8'($urandom_range(0, 254)) ^ SYNC_BYTE ^ SYNC_BYTE);
      repeat ($urandom_range(0, 3)) send_byte(pick_data_byte());
    end else begin
      repeat ($urandom_range(1, 8)) send_byte(pick_data_byte());
    end
  endtask

  // Result side: random stalls, long ready stretches, and one long hold-off
  initial begin
    int stall;
    bit hold_off_done;
    hold_off_done = 1'b0;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req && !hold_off_done) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_done = 1'b1;
      end else begin
        res_ch.ready <= 1'b1;
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(50, 150)) @(posedge clk);
        else repeat ($urandom_range(1, 6)) @(posedge clk);
        stall = pick_gap();
        if (stall > 0) begin
          res_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no activity for %0d cycles", IDLE_LIMIT);
      $display("** ultrasonic_frame_parser: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [15:0] setting;
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    rx_ch.valid   <= 1'b0;
    rx_ch.rx_byte <= 8'd0;
    bytes_sent    = 0;
    settings_used = 0;
    steady_sender = 1'b0;
    hold_off_req  = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme bytes and a sync byte followed by a non-sync byte
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(SYNC_BYTE);
    send_byte(8'h55);
    // Both distances zero take the reset no-echo value
    send_frame(TYPE_DIST, 16'd0, 16'd0);
    send_frame(TYPE_DIST, 16'hFFFF, 16'd1);
    send_frame(TYPE_DIST, 16'h1234, 16'h1234);
    send_frame(TYPE_DIST, 16'hFFFF, 16'd0);
    // Frames of other kinds pass silently, including one whose kind is a sync byte
    send_frame(8'h01, 16'd0, 16'd0);
    send_frame(SYNC_BYTE, 16'h00FF, 16'hFF00);
    // A third sync byte shifts the frame by one
    send_byte(SYNC_BYTE);
    send_frame(TYPE_DIST, 16'h8000, 16'h7FFF);

    // Random phases, each under its own no-echo setting
    while (bytes_sent < ITEM_TARGET) begin
      settle();
      case (settings_used % 4)
        0: setting = 16'd0;
        1: setting = 16'hFFFF;
        2: setting = 16'($urandom_range(0, 65535));
        default: setting = NO_ECHO_RESET;
      endcase
      if (settings_used == 0) apb_write(SPARE_ADDR, CFG_DATA_W'($urandom));
      apb_write(NO_ECHO_ADDR, {16'($urandom_range(0, 65535)), setting});
      // Stall the result side long enough to back up the input
      if (settings_used == 1) hold_off_req = 1'b1;
      settings_used++;
      for (int n = bytes_sent + PHASE_ITEMS; bytes_sent < n; ) send_random_burst();
    end

    rx_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run sent %0d bytes under %0d no-echo settings;", bytes_sent, settings_used + 1);
    $display("%0d distance results predicted, %0d checked.", predicted, delivered);
    if (mismatches == 0 && pending == 0) begin
      $display("** ultrasonic_frame_parser: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending);
      $display("** ultrasonic_frame_parser: FAILED **");
    end
    $finish;
  end

endmodule
